[rtl/bmpdec_pkg.sv]
// bmpdec_pkg: shared constants and result type for the BMP 24-bit decoder.
// No dependencies; imported by the decoder top level and its checker.
`default_nettype none
package bmpdec_pkg;

  // Header layout: total header length and the stream positions at which
  // each little-endian field is complete.
  localparam logic [31:0] HEADER_BYTES = 32'd54;
  localparam logic [5:0]  POS_MAGIC    = 6'd1;
  localparam logic [5:0]  POS_OFFSET   = 6'd13;
  localparam logic [5:0]  POS_WIDTH    = 6'd21;
  localparam logic [5:0]  POS_HEIGHT   = 6'd25;
  localparam logic [5:0]  POS_PLANES   = 6'd27;
  localparam logic [5:0]  POS_DEPTH    = 6'd29;
  localparam logic [5:0]  POS_COMPR    = 6'd33;

  localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
  localparam logic [15:0] BMP_PLANES   = 16'd1;
  localparam logic [15:0] BMP_DEPTH    = 16'd24;
  localparam logic [31:0] BI_RGB       = 32'd0;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MAGIC       = 3'd1;
  localparam logic [2:0] ST_PLANES      = 3'd2;
  localparam logic [2:0] ST_DEPTH       = 3'd3;
  localparam logic [2:0] ST_COMPRESSION = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;
  localparam logic [2:0] ST_TRUNCATED   = 3'd6;

  typedef struct packed {
    logic        pixel_valid;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [31:0] argb;
    logic        end_of_file;
    logic [2:0]  status;
  } res_t;

endpackage
`default_nettype wire

[rtl/bmp_bgr24_to_argb_decoder.sv]
// bmp_bgr24_to_argb_decoder: byte-stream BMP (24-bit BGR) parser and pixel emitter.
// Depends on bmpdec_pkg (constants, result struct).
//
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+-----------------
//  in      | in_data_byte[7:0], in_last_byte                   | in_valid/in_ready
//  out     | out_pixel_valid, out_dest_x/y[11:0], out_argb,    | out_valid/out_ready
//          | out_end_of_file, out_status[2:0]                  |
//
// One byte per clock while in_ready is high: parser state and any result are both
// registered when a byte is taken, the result into the output register or the skid.
// The output side has a register plus one skid entry, so in_ready depends only
// on the skid entry and a waiting result does not stop input.
// Sustained rate is one byte per cycle as long as out_ready keeps up.
// Synchronous active-low reset clears parser and handshake state; there is
// no clearing pass. A byte marked last returns the parser to its reset state.
`default_nettype none
module bmp_bgr24_to_argb_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_pixel_valid,
  output logic [11:0]      out_dest_x,
  output logic [11:0]      out_dest_y,
  output logic [31:0]      out_argb,
  output logic             out_end_of_file,
  output logic [2:0]       out_status
);
  import bmpdec_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Parser state
  logic [31:0]   pos_r, pos_nxt;          // saturating byte counter
  logic [31:0]   shift_r, shift_nxt;      // little-endian header collector
  logic [31:0]   offset_r, offset_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic          neg_height_r, neg_height_nxt;
  logic [15:0]   bg_r, bg_nxt;            // green, blue of pixel in progress
  logic [1:0]    bip_r, bip_nxt;          // byte in pixel
  logic [WW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic          failed_r, failed_nxt;
  logic [2:0]    err_r, err_nxt;

  // Output register and skid entry
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic          in_fire, out_fire, has_result;
  logic [31:0]   shift_v, hmag;
  logic [15:0]   half;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] py_full;
  logic          truncated;
  res_t          res;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign shift_v = {in_data_byte, shift_r[31:8]};
  assign half    = shift_v[31:16];
  assign hmag    = shift_v[31] ? (32'd0 - shift_v) : shift_v;
  assign col_inc = col_r + WW'(1);
  assign py_full = neg_height_r ? row_r : (height_r - HW'(1) - row_r);

  always_comb begin
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    offset_nxt     = offset_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    neg_height_nxt = neg_height_r;
    bg_nxt         = bg_r;
    bip_nxt        = bip_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pad_nxt        = pad_r;
    failed_nxt     = failed_r;
    err_nxt        = err_r;
    res            = '0;

    if (!failed_r) begin
      if (pos_r < HEADER_BYTES) begin
        shift_nxt = shift_v;
        case (pos_r[5:0])
          POS_MAGIC: begin
            if (half != BMP_MAGIC) res.status = ST_MAGIC;
          end
          POS_OFFSET: begin
            offset_nxt = shift_v;
          end
          POS_WIDTH: begin
            if (shift_v[31] || shift_v > 32'(MAX_WIDTH)) res.status = ST_TOO_LARGE;
            else width_nxt = shift_v[WW-1:0];
          end
          POS_HEIGHT: begin
            if (hmag > 32'(MAX_HEIGHT)) begin
              res.status = ST_TOO_LARGE;
            end else begin
              height_nxt     = hmag[HW-1:0];
              neg_height_nxt = shift_v[31];
            end
          end
          POS_PLANES: begin
            if (half != BMP_PLANES) res.status = ST_PLANES;
          end
          POS_DEPTH: begin
            if (half != BMP_DEPTH) res.status = ST_DEPTH;
          end
          POS_COMPR: begin
            if (shift_v != BI_RGB) res.status = ST_COMPRESSION;
          end
          default: ;
        endcase
        if (res.status != ST_OK) begin
          failed_nxt = 1'b1;
          err_nxt    = res.status;
        end
      end else if (pos_r >= offset_r && row_r < height_r && width_r != '0) begin
        // Pixel data: drain row padding, else collect B, G, R.
        if (pad_r != 2'd0) begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            col_nxt = '0;
            row_nxt = row_r + HW'(1);
          end
        end else if (bip_r == 2'd0) begin
          bg_nxt  = {8'd0, in_data_byte};
          bip_nxt = 2'd1;
        end else if (bip_r == 2'd1) begin
          bg_nxt  = {in_data_byte, bg_r[7:0]};
          bip_nxt = 2'd2;
        end else begin
          res.pixel_valid = 1'b1;
          res.dest_x      = 12'(col_r);
          res.dest_y      = 12'(py_full);
          res.argb        = {ALPHA_OPAQUE, in_data_byte, bg_r};
          bip_nxt         = 2'd0;
          col_nxt         = col_inc;
          if (col_inc >= width_r) begin
            if (2'(width_r) == 2'd0) begin
              col_nxt = '0;
              row_nxt = row_r + HW'(1);
            end else begin
              pad_nxt = 2'(width_r);
            end
          end
        end
      end
    end

    if (pos_r != '1) pos_nxt = pos_r + 32'd1;

    // Truncation looks at the state after this byte.
    truncated = (pos_nxt < HEADER_BYTES) || (width_nxt != '0 && row_nxt < height_nxt);

    has_result = in_last_byte || res.pixel_valid || (res.status != ST_OK);

    if (in_last_byte) begin
      res.end_of_file = 1'b1;
      if (failed_nxt)     res.status = err_nxt;
      else if (truncated) res.status = ST_TRUNCATED;
      else                res.status = ST_OK;
      // Drop all parser state for the next file.
      pos_nxt        = '0;
      shift_nxt      = '0;
      offset_nxt     = '0;
      width_nxt      = '0;
      height_nxt     = '0;
      neg_height_nxt = 1'b0;
      bg_nxt         = '0;
      bip_nxt        = 2'd0;
      col_nxt        = '0;
      row_nxt        = '0;
      pad_nxt        = 2'd0;
      failed_nxt     = 1'b0;
      err_nxt        = ST_OK;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      shift_r      <= '0;
      offset_r     <= '0;
      width_r      <= '0;
      height_r     <= '0;
      neg_height_r <= 1'b0;
      bg_r         <= '0;
      bip_r        <= 2'd0;
      col_r        <= '0;
      row_r        <= '0;
      pad_r        <= 2'd0;
      failed_r     <= 1'b0;
      err_r        <= ST_OK;
    end else if (in_fire) begin
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      offset_r     <= offset_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      neg_height_r <= neg_height_nxt;
      bg_r         <= bg_nxt;
      bip_r        <= bip_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      pad_r        <= pad_nxt;
      failed_r     <= failed_nxt;
      err_r        <= err_nxt;
    end
  end

  // Output register with one skid entry. A new result goes straight to the
  // output register when it is free or being drained, else into the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && has_result) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_r.pixel_valid;
  assign out_dest_x      = out_r.dest_x;
  assign out_dest_y      = out_r.dest_y;
  assign out_argb        = out_r.argb;
  assign out_end_of_file = out_r.end_of_file;
  assign out_status      = out_r.status;

endmodule
`default_nettype wire

[rtl/bmpdec_checker.sv]
// bmpdec_checker: port-level assertions for the BMP decoder, bound to the top.
// Depends on bmpdec_pkg (status codes) and bmp_bgr24_to_argb_decoder.
`default_nettype none
module bmpdec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_pixel_valid,
  input wire logic [11:0] out_dest_x,
  input wire logic [11:0] out_dest_y,
  input wire logic [31:0] out_argb,
  input wire logic        out_end_of_file,
  input wire logic [2:0]  out_status
);
  import bmpdec_pkg::*;

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_argb) && $stable(out_status)
      && $stable(out_dest_x) && $stable(out_dest_y) && $stable(out_end_of_file))
    else $error("result changed while stalled");

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |-> out_argb[31:24] == ALPHA_OPAQUE)
    else $error("pixel not opaque");

  // A pixel on the last byte may carry the truncation status.
  a_pixel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid && !out_end_of_file |-> out_status == ST_OK)
    else $error("pixel carries error status");

  a_nopix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_argb == 32'd0 && out_dest_x == 12'd0
      && out_dest_y == 12'd0)
    else $error("non-pixel result has pixel fields");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid && !out_end_of_file |-> out_status != ST_OK)
    else $error("result without pixel, error or end of file");

endmodule

bind bmp_bgr24_to_argb_decoder bmpdec_checker u_bmpdec_checker (.*);
`default_nettype wire

[tb/tb_bmp_bgr24_to_argb_decoder.sv]
// Self-checking testbench for bmp_bgr24_to_argb_decoder: streams BMP files one
// byte at a time and checks every pixel, error report and end-of-file result.
// Depends on bmpdec_pkg and the decoder RTL only.
`default_nettype none
module tb_bmp_bgr24_to_argb_decoder;
  import bmpdec_pkg::*;

  localparam int MAX_W       = 4096;
  localparam int MAX_H       = 4096;
  localparam int ITEM_GOAL   = 1300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX  = 10;

  // Scoreboard: tracks the parser state from accepted bytes and holds the
  // results the decoder owes, oldest first.
  class pixel_scoreboard;
    bit [31:0] byte_count;
    bit [31:0] field_shift;
    bit [31:0] pixel_start;
    bit [12:0] width_px;
    bit [12:0] height_px;
    bit [12:0] col_idx;
    bit [12:0] row_idx;
    bit        neg_height;
    bit        halted;
    bit [15:0] bg_hold;
    bit [1:0]  byte_phase;
    bit [1:0]  pad_left;
    res_t      expected_q[$];
    int        mismatches;
    int        checked;
    int        live_bytes;
    int        pixels_expected;
    int        reports_expected;
    int        files_done;

    function void clear_parser();
      byte_count  = '0;
      field_shift = '0;
      pixel_start = '0;
      width_px    = '0;
      height_px   = '0;
      col_idx     = '0;
      row_idx     = '0;
      neg_height  = 1'b0;
      halted      = 1'b0;
      bg_hold     = '0;
      byte_phase  = '0;
      pad_left    = '0;
    endfunction

    // Latch the first error; the shift register keeps its code for end of file.
    function bit [2:0] halt(bit [2:0] code);
      halted      = 1'b1;
      field_shift = {29'd0, code};
      return code;
    endfunction

    function void start_next_row();
      col_idx = '0;
      row_idx = row_idx + 13'd1;
    endfunction

    // Act on a header field whose last byte has just arrived.
    function bit [2:0] check_field(bit [5:0] at);
      bit [31:0] mag;
      case (at)
        POS_MAGIC: begin
          if (field_shift[31:16] != BMP_MAGIC) return halt(ST_MAGIC);
        end
        POS_OFFSET: pixel_start = field_shift;
        POS_WIDTH: begin
          if (field_shift[31] || field_shift > MAX_W) return halt(ST_TOO_LARGE);
          width_px = field_shift[12:0];
        end
        POS_HEIGHT: begin
          mag = field_shift[31] ? 32'd0 - field_shift : field_shift;
          if (mag > MAX_H) return halt(ST_TOO_LARGE);
          height_px  = mag[12:0];
          neg_height = field_shift[31];
        end
        POS_PLANES: begin
          if (field_shift[31:16] != BMP_PLANES) return halt(ST_PLANES);
        end
        POS_DEPTH: begin
          if (field_shift[31:16] != BMP_DEPTH) return halt(ST_DEPTH);
        end
        POS_COMPR: begin
          if (field_shift != BI_RGB) return halt(ST_COMPRESSION);
        end
        default: ;
      endcase
      return ST_OK;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      res_t      r;
      bit [2:0]  st;
      bit [31:0] first_pix;
      bit [12:0] flip_row;
      r  = '0;
      st = ST_OK;
      if (!halted) begin
        live_bytes++;
        if (byte_count < HEADER_BYTES) begin
          field_shift = {b, field_shift[31:8]};
          st = check_field(byte_count[5:0]);
        end else begin
          first_pix = (pixel_start < HEADER_BYTES) ? HEADER_BYTES : pixel_start;
          if (byte_count >= first_pix && row_idx < height_px && width_px != 0) begin
            if (pad_left != 0) begin
              pad_left = pad_left - 2'd1;
              if (pad_left == 0) start_next_row();
            end else if (byte_phase == 2'd0) begin
              bg_hold    = {8'h00, b};
              byte_phase = 2'd1;
            end else if (byte_phase == 2'd1) begin
              bg_hold[15:8] = b;
              byte_phase    = 2'd2;
            end else begin
              flip_row      = height_px - 13'd1 - row_idx;
              r.pixel_valid = 1'b1;
              r.dest_x      = col_idx[11:0];
              r.dest_y      = neg_height ? row_idx[11:0] : flip_row[11:0];
              r.argb        = {ALPHA_OPAQUE, b, bg_hold};
              byte_phase    = 2'd0;
              col_idx       = col_idx + 13'd1;
              if (col_idx >= width_px) begin
                if (width_px[1:0] == 2'd0) start_next_row();
                else pad_left = width_px[1:0];
              end
            end
          end
        end
      end
      if (byte_count != 32'hFFFF_FFFF) byte_count++;

      if (last) begin
        if (halted) st = field_shift[2:0];
        else if (byte_count < HEADER_BYTES || (width_px != 0 && row_idx < height_px))
          st = ST_TRUNCATED;
        else st = ST_OK;
        r.end_of_file = 1'b1;
        files_done++;
        clear_parser();
      end else if (!r.pixel_valid && st == ST_OK) begin
        return;
      end
      r.status = st;
      if (r.pixel_valid) pixels_expected++;
      if (st != ST_OK) reports_expected++;
      expected_q.push_back(r);
    endfunction

    function string describe(res_t r);
      return $sformatf("pix=%0b x=%0d y=%0d argb=%h eof=%0b status=%0d",
                       r.pixel_valid, r.dest_x, r.dest_y, r.argb, r.end_of_file, r.status);
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing pending: %s", $time, describe(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.pixel_valid !== want.pixel_valid || got.dest_x !== want.dest_x ||
          got.dest_y !== want.dest_y || got.argb !== want.argb ||
          got.end_of_file !== want.end_of_file || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $time, describe(want), describe(got));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_pixel_valid;
  logic [11:0] out_dest_x;
  logic [11:0] out_dest_y;
  logic [31:0] out_argb;
  logic        out_end_of_file;
  logic [2:0]  out_status;

  pixel_scoreboard sb;
  bit [7:0]        file_bytes[$];
  res_t            seen;
  int              cycle_count;
  int              sent_bytes;

  bmp_bgr24_to_argb_decoder #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_valid(out_pixel_valid),
    .out_dest_x     (out_dest_x),
    .out_dest_y     (out_dest_y),
    .out_argb       (out_argb),
    .out_end_of_file(out_end_of_file),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bmp_bgr24_to_argb_decoder test failed");
      $finish;
    end
  end

  // Monitor: sample both channels at the rising edge. Record the input
  // transaction first so a same-edge result always finds its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready) begin
        seen = {out_pixel_valid, out_dest_x, out_dest_y, out_argb,
                out_end_of_file, out_status};
        sb.check_result(seen);
      end
    end
  end

  // Result sink: stall at random before each result, with occasional
  // stretches of back-to-back acceptance.
  initial begin : result_sink
    int stall;
    int eager_left;
    eager_left = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (eager_left > 0) begin
        stall = 0;
        eager_left--;
      end else begin
        stall = $urandom_range(0, 15);
        if ($urandom_range(0, 9) == 0) eager_left = $urandom_range(20, 60);
      end
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Drive one byte transaction; hold valid and payload until accepted.
  task automatic send_byte(input bit [7:0] b, input bit last, input bit gapless);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit gapless);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1, gapless);
  endtask

  // Hold the input idle until every owed result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic put_le(input bit [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  // Start a new file: 14-byte file header, 40-byte info header, then filler
  // up to the pixel offset.
  task automatic build_header(input bit [15:0] magic, input bit [31:0] offset,
                              input bit [31:0] w, input bit [31:0] h,
                              input bit [15:0] planes, input bit [15:0] depth,
                              input bit [31:0] compr);
    file_bytes.delete();
    put_le(magic, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(offset, 4);
    put_le(32'd40, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(planes, 2);
    put_le(depth, 2);
    put_le(compr, 4);
    repeat (5) put_le($urandom, 4);
    if (offset > HEADER_BYTES && offset < 32'd1024)
      repeat (offset - HEADER_BYTES) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic good_header(input bit [31:0] offset, input bit [31:0] w,
                             input bit [31:0] h);
    build_header(BMP_MAGIC, offset, w, h, BMP_PLANES, BMP_DEPTH, BI_RGB);
  endtask

  // Random BGR rows, each padded out to a 4-byte boundary.
  task automatic put_pixels(input int w, input int rows);
    repeat (rows) begin
      repeat (3 * w) file_bytes.push_back($urandom_range(0, 255));
      repeat (w % 4) file_bytes.push_back($urandom_range(0, 255));
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic cut_to(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  initial begin : stimulus
    bit [7:0] extreme_rows[16];
    int       live_goal;
    int       w;
    int       h;
    int       rows;
    int       off;
    int       idx;
    extreme_rows = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h55,
                     8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA};
    sb           = new();
    sb.clear_parser();
    cycle_count  = 0;
    sent_bytes   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready    = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed files.
    // 2x2 bottom-up with all-ones, all-zeros and mixed pixels.
    good_header(54, 2, 2);
    foreach (extreme_rows[i]) file_bytes.push_back(extreme_rows[i]);
    send_file(1'b1);
    // Top-down 3x2, pixel data past a gap after the header, trailing bytes.
    good_header(60, 3, -2);
    put_pixels(3, 2);
    put_noise(3);
    send_file(1'b0);
    // Offset pointing inside the header: data starts right after it.
    good_header(0, 1, 3);
    put_pixels(1, 3);
    send_file(1'b0);
    // No padding: the last byte completes the last pixel.
    good_header(54, 4, 1);
    put_pixels(4, 1);
    send_file(1'b0);
    // Bad magic, then bytes that must be ignored.
    build_header(16'h4E42, 54, 1, 1, BMP_PLANES, BMP_DEPTH, BI_RGB);
    cut_to(6);
    send_file(1'b0);
    // Each header check in turn.
    build_header(BMP_MAGIC, 54, 1, 1, BMP_PLANES + 16'd1, BMP_DEPTH, BI_RGB);
    put_pixels(1, 1);
    send_file(1'b1);
    build_header(BMP_MAGIC, 54, 1, 1, BMP_PLANES, 16'd32, BI_RGB);
    put_pixels(1, 1);
    send_file(1'b0);
    build_header(BMP_MAGIC, 54, 1, 1, BMP_PLANES, BMP_DEPTH, BI_RGB + 32'd1);
    put_pixels(1, 1);
    send_file(1'b0);
    // Size limits: too wide, negative width, too tall (top-down).
    good_header(54, MAX_W + 1, 1);
    send_file(1'b0);
    good_header(54, 32'hFFFF_FFFF, 1);
    send_file(1'b1);
    good_header(54, 1, -(MAX_H + 1));
    send_file(1'b0);
    // Oversized width wins over bad planes, since it arrives first.
    build_header(BMP_MAGIC, 54, 5000, 1, 16'd0, BMP_DEPTH, BI_RGB);
    send_file(1'b0);
    // Largest sizes with an empty image: accepted, no pixels.
    good_header(54, MAX_W, 0);
    send_file(1'b0);
    good_header(54, 0, MAX_H);
    send_file(1'b0);
    good_header(54, 0, -MAX_H);
    send_file(1'b1);
    // Truncation in the header, in the pixel data, and a one-byte file.
    good_header(54, 2, 2);
    cut_to(20);
    send_file(1'b0);
    good_header(54, 2, 2);
    put_pixels(2, 2);
    cut_to(59);
    send_file(1'b0);
    file_bytes.delete();
    file_bytes.push_back(8'h42);
    send_file(1'b0);
    drain_results();

    // Random files until the byte budget is spent: mostly well-formed with
    // random content, the rest corrupted, truncated or pure noise.
    live_goal = ITEM_GOAL;
    while (sent_bytes < live_goal) begin
      if ($urandom_range(0, 11) == 0) drain_results();
      w    = $urandom_range(0, 5);
      h    = int'($urandom_range(0, 8)) - 4;
      rows = (h < 0) ? -h : h;
      case ($urandom_range(0, 3))
        1:       off = 54 + $urandom_range(1, 6);
        2:       off = $urandom_range(0, 53);
        default: off = 54;
      endcase
      case ($urandom_range(0, 9))
        6: begin
          // Corrupt one header byte with a random value.
          good_header(off, w, h);
          put_pixels(w, rows);
          idx = $urandom_range(0, 33);
          file_bytes[idx] = $urandom_range(0, 255);
        end
        7: begin
          case ($urandom_range(0, 5))
            0:       good_header(54, MAX_W, 0);
            1:       good_header(54, MAX_W + 1, 1);
            2:       good_header(54, 32'h8000_0000, 1);
            3:       good_header(54, 0, MAX_H);
            4:       good_header(54, 0, -MAX_H);
            default: good_header(54, 1, 32'h8000_0000);
          endcase
          put_noise($urandom_range(0, 4));
        end
        8: begin
          file_bytes.delete();
          if ($urandom_range(0, 1) == 1) put_le({16'd0, BMP_MAGIC}, 2);
          put_noise($urandom_range(1, 60));
        end
        9: begin
          good_header(off, w, h);
          cut_to($urandom_range(1, 54));
        end
        default: begin
          good_header(off, w, h);
          put_pixels(w, rows);
          if ($urandom_range(0, 4) == 0) cut_to($urandom_range(1, file_bytes.size()));
          else if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 5));
        end
      endcase
      send_file($urandom_range(0, 3) == 0);
    end

    // Drain, then give any stray result time to show up.
    drain_results();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
    $display("Streamed %0d files (%0d bytes sent, %0d parsed), checked %0d results",
             sb.files_done, sent_bytes, sb.live_bytes, sb.checked);
    $display("Covered %0d pixels and %0d error or truncation reports, %0d mismatches",
             sb.pixels_expected, sb.reports_expected, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bmp_bgr24_to_argb_decoder test passed");
    end else begin
      $display("bmp_bgr24_to_argb_decoder test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[bmp_bgr24_to_argb_decoder.f]
rtl/bmpdec_pkg.sv
rtl/bmp_bgr24_to_argb_decoder.sv
rtl/bmpdec_checker.sv
tb/tb_bmp_bgr24_to_argb_decoder.sv
